FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
// ASSERT_PROP: the property must hold at every rising clock edge outside reset.
// ASSERT_NEVER: the expression must never be true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion %m failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion %m failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: design/itpc_pkg.sv
package itpc_pkg;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;

   // Stack commands from the sequencer; at most one of push/pop per cycle.
   typedef struct packed {
      logic push;
      logic pop;
      logic read;
   } stk_cmd_type;

   function automatic logic is_operand(input logic [7:0] c);
      is_operand = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      unique case (c)
         CH_PLUS, CH_MINUS: prec_of = 2'd1;
         CH_STAR, CH_SLASH: prec_of = 2'd2;
         CH_CARET:          prec_of = 2'd3;
         default:           prec_of = 2'd0;
      endcase
   endfunction

endpackage

FILE: design/itpc_stack.sv
`include "assert_macros.svh"

module itpc_stack #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  itpc_pkg::stk_cmd_type              cmd,
   input  logic [7:0]                         push_data,
   output logic [$clog2(STACK_DEPTH+1)-1:0]   count,
   output logic [7:0]                         top_data
);
   import itpc_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    mem [STACK_DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] below_top;
   logic [7:0]    top_ff;

   assign below_top = count_ff - CW'(1);
   assign count     = count_ff;
   assign top_data  = top_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = below_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Write at the free slot, read the top entry into a register in the cycle after the request.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[count_ff[AW-1:0]] <= push_data;
      end
      if (cmd.read) begin
         top_ff <= mem[below_top[AW-1:0]];
      end
   end

   `ASSERT_NEVER(a_push_full, clock, reset, cmd.push && (count_ff >= CW'(STACK_DEPTH)))
   `ASSERT_NEVER(a_pop_empty, clock, reset, (cmd.pop || cmd.read) && (count_ff == '0))
   `ASSERT_NEVER(a_push_pop, clock, reset, cmd.push && cmd.pop)

endmodule

FILE: design/infix_to_postfix_converter_unit.sv
// Channel  Ports                 Payload (low bit up)
// -------  --------------------  ----------------------------------------------
// req      req_tvalid/tready     tdata: in_char[7:0]; tuser: action
// rsp      rsp_tvalid/tready     tdata: out_char[7:0]; tuser: end_mark,
//                                error_code[1:0]; tlast: last_of_run
//
// Steps: an operand byte passes the idle, tail and finish states; each stack pop,
//   and the compare that stops the popping, passes read then evaluate (top read
//   through the stack RAM's registered port, then compare); a push adds the push
//   state; the end marker or an error result adds tail; closing adds finish.
// req_tready is high only while the sequencer is idle; one item is in work.
// Reset (synchronous, active high) empties the stack and drops queued results;
//   stack contents are not cleared and need no clearing pass.
// A stall on rsp holds the sequencer at its next result; the final result of an
//   item waits in the output register while the next item is taken.
`include "assert_macros.svh"

module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic [0:0] req_tuser,   // [0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [0] end_mark, [2:1] error_code
   output logic       rsp_tlast
);
   import itpc_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_PUSH = 3'd3;
   localparam logic [2:0] S_TAIL = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // what the current item does with popped entries
   localparam logic [1:0] K_END   = 2'd0;
   localparam logic [1:0] K_CLOSE = 2'd1;
   localparam logic [1:0] K_OPER  = 2'd2;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    char_ff, char_in;
   logic [1:0]    prec_ff, prec_in;
   logic [7:0]    tail_char_ff, tail_char_in;
   logic          tail_end_ff, tail_end_in;
   logic [1:0]    tail_err_ff, tail_err_in;

   // pending result: held back one step so its last flag is known
   logic          pend_valid_ff;
   logic [7:0]    pend_char_ff;
   logic          pend_end_ff;
   logic [1:0]    pend_err_ff;

   logic          out_valid_ff;
   logic [7:0]    out_char_ff;
   logic          out_end_ff;
   logic [1:0]    out_err_ff;
   logic          out_last_ff;

   logic          req_fire;
   logic          out_free;
   logic          can_emit;
   logic          emit;
   logic [7:0]    emit_char;
   logic          emit_end;
   logic [1:0]    emit_err;
   logic          fin_move;
   logic          out_load;
   logic          out_last_in;
   stk_cmd_type   cmd;
   logic [CW-1:0] count;
   logic [7:0]    top_data;
   logic          last_entry;

   itpc_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .push_data (char_ff),
      .count     (count),
      .top_data  (top_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   // a new result may enter the pending slot once that slot can move out
   assign can_emit   = !pend_valid_ff || out_free;
   assign last_entry = (count == CW'(1));

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      prec_in      = prec_ff;
      tail_char_in = tail_char_ff;
      tail_end_in  = tail_end_ff;
      tail_err_in  = tail_err_ff;
      emit         = 1'b0;
      emit_char    = top_data;
      emit_end     = 1'b0;
      emit_err     = ERR_NONE;
      fin_move     = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               char_in      = req_tdata;
               prec_in      = prec_of(req_tdata);
               tail_char_in = 8'h00;
               tail_end_in  = 1'b0;
               tail_err_in  = ERR_OVERFLOW;
               kind_in      = K_OPER;
               if (req_tuser[0]) begin
                  // end of expression: flush, then end marker
                  kind_in     = K_END;
                  tail_end_in = 1'b1;
                  tail_err_in = ERR_NONE;
                  state_in    = (count != '0) ? S_READ : S_TAIL;
               end else if (is_operand(req_tdata)) begin
                  tail_char_in = req_tdata;
                  tail_err_in  = ERR_NONE;
                  state_in     = S_TAIL;
               end else if (req_tdata == CH_OPEN) begin
                  state_in = S_PUSH;
               end else if (req_tdata == CH_CLOSE) begin
                  kind_in     = K_CLOSE;
                  tail_err_in = ERR_UNMATCHED;
                  state_in    = (count != '0) ? S_READ : S_TAIL;
               end else begin
                  state_in = (count != '0) ? S_READ : S_PUSH;
               end
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            unique case (kind_ff)
               K_END: begin
                  if (can_emit) begin
                     emit     = 1'b1;
                     cmd.pop  = 1'b1;
                     state_in = last_entry ? S_TAIL : S_READ;
                  end
               end
               K_CLOSE: begin
                  if (top_data == CH_OPEN) begin
                     // matching open paren: drop it silently
                     cmd.pop  = 1'b1;
                     state_in = S_FIN;
                  end else if (can_emit) begin
                     emit     = 1'b1;
                     cmd.pop  = 1'b1;
                     state_in = last_entry ? S_TAIL : S_READ;
                  end
               end
               default: begin
                  if (prec_of(top_data) >= prec_ff) begin
                     if (can_emit) begin
                        emit     = 1'b1;
                        cmd.pop  = 1'b1;
                        state_in = last_entry ? S_PUSH : S_READ;
                     end
                  end else begin
                     state_in = S_PUSH;
                  end
               end
            endcase
         end
         S_PUSH: begin
            if (count < CW'(STACK_DEPTH)) begin
               cmd.push = 1'b1;
               state_in = S_FIN;
            end else begin
               // full stack: drop the byte and report overflow
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            emit_char = tail_char_ff;
            emit_end  = tail_end_ff;
            emit_err  = tail_err_ff;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // release the held result with its last flag, if any
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               fin_move = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_load    = (emit && pend_valid_ff) || fin_move;
   assign out_last_in = fin_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            pend_valid_ff <= 1'b1;
         end else if (fin_move) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      prec_ff      <= prec_in;
      tail_char_ff <= tail_char_in;
      tail_end_ff  <= tail_end_in;
      tail_err_ff  <= tail_err_in;
      if (emit) begin
         pend_char_ff <= emit_end || (emit_err != ERR_NONE) ? 8'h00 : emit_char;
         pend_end_ff  <= emit_end;
         pend_err_ff  <= emit_err;
      end
      if (out_load) begin
         out_char_ff <= pend_char_ff;
         out_end_ff  <= pend_end_ff;
         out_err_ff  <= pend_err_ff;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = {out_err_ff, out_end_ff};
   assign rsp_tlast  = out_last_ff;

   `ASSERT_NEVER(a_idle_pend_empty, clock, reset, req_tready && pend_valid_ff)
   `ASSERT_PROP(a_one_item, clock, reset, req_fire |=> !req_tready)
   `ASSERT_NEVER(a_last_only_fin, clock, reset, out_load && out_last_in && (state_ff != S_FIN))
   `ASSERT_NEVER(a_no_overrun, clock, reset, out_load && out_valid_ff && !rsp_tready)

endmodule
